### hw/rtl/psu_pkg.sv
`default_nettype none

package psu_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int PRIO_WIDTH  = 8;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int ENTRY_W     = VALUE_WIDTH + PRIO_WIDTH;

  // operation codes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef struct packed {
    logic                   mode;
    logic [VALUE_WIDTH-1:0] item_value;
    logic [PRIO_WIDTH-1:0]  item_priority;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] top_value;
    logic [PRIO_WIDTH-1:0]  top_priority;
    logic                   is_empty;
    logic [CNT_W-1:0]       entry_count;
    logic                   op_error;
  } out_word_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [PRIO_WIDTH-1:0]  prio;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_POP_RD,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic ready;
    logic done;
  } seq_stat_t;

endpackage

`default_nettype wire

### hw/rtl/psu_ram.sv
`default_nettype none

module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/psu_seq.sv
`default_nettype none

module psu_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  psu_pkg::in_word_t   in_word,
  input  logic                out_free,
  output psu_pkg::seq_stat_t  stat,
  output psu_pkg::out_word_t  result,
  output psu_pkg::ram_req_t   ram_req,
  input  psu_pkg::entry_t     rdata
);
  import psu_pkg::*;

  seq_state_t       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] idx, idx_next;
  entry_t           top, top_next;
  entry_t           new_ent, new_ent_next;
  logic             err, err_next;
  logic             mode, mode_next;
  entry_t           in_ent;
  logic             shift;

  // slot 0 is the bottom of the stack, slot count-1 the top
  assign in_ent = '{value: in_word.item_value, prio: in_word.item_priority};

  // the scan comparator: stored entry outranks the new one, so it moves up
  assign shift = rdata.prio > new_ent.prio;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx     <= idx_next;
    top     <= top_next;
    new_ent <= new_ent_next;
    err     <= err_next;
    mode    <= mode_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    idx_next      = idx;
    top_next      = top;
    new_ent_next  = new_ent;
    err_next      = err;
    mode_next     = mode;
    ram_req       = '0;
    ram_req.raddr = idx;
    case (state)
      ST_IDLE: begin
        if (start) begin
          new_ent_next = in_ent;
          err_next     = 1'b0;
          mode_next    = in_word.mode;
          if (in_word.mode == MODE_PUSH) begin
            if (count == CNT_W'(DEPTH)) begin
              err_next   = 1'b1;
              state_next = ST_DONE;
            end else if (count == '0) begin
              ram_req.we    = 1'b1;
              ram_req.waddr = '0;
              ram_req.wdata = in_ent;
              top_next      = in_ent;
              count_next    = CNT_W'(1);
              state_next    = ST_DONE;
            end else begin
              ram_req.raddr = IDX_W'(count - CNT_W'(1));
              idx_next      = IDX_W'(count - CNT_W'(1));
              state_next    = ST_SCAN;
            end
          end else begin
            if (count == '0) begin
              err_next   = 1'b1;
              state_next = ST_DONE;
            end else if (count == CNT_W'(1)) begin
              count_next = '0;
              state_next = ST_DONE;
            end else begin
              count_next    = count - CNT_W'(1);
              ram_req.raddr = IDX_W'(count - CNT_W'(2));
              state_next    = ST_POP_RD;
            end
          end
        end
      end
      ST_SCAN: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = IDX_W'(idx + IDX_W'(1));
        if (shift) begin
          ram_req.wdata = rdata;
          if (idx == '0) begin
            state_next = ST_INSERT;
          end else begin
            idx_next      = idx - IDX_W'(1);
            ram_req.raddr = idx - IDX_W'(1);
          end
        end else begin
          ram_req.wdata = new_ent;
          count_next    = count + CNT_W'(1);
          if (idx == IDX_W'(count - CNT_W'(1))) begin
            top_next = new_ent;
          end
          state_next = ST_DONE;
        end
      end
      ST_INSERT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = '0;
        ram_req.wdata = new_ent;
        count_next    = count + CNT_W'(1);
        state_next    = ST_DONE;
      end
      ST_POP_RD: begin
        top_next   = rdata;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign stat.ready = (state == ST_IDLE);
  assign stat.done  = (state == ST_DONE);

  always_comb begin
    result.is_empty     = (count == '0);
    result.top_value    = result.is_empty ? '0 : top.value;
    result.top_priority = result.is_empty ? '0 : top.prio;
    result.entry_count  = count;
    result.op_error     = err;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_full_push_refused: assert property (@(posedge clk) disable iff (rst)
    (start && stat.ready && in_word.mode == MODE_PUSH && count == CNT_W'(DEPTH))
    |=> (state == ST_DONE && err && count == CNT_W'(DEPTH)))
    else $error("push on full store not refused");

  a_scan_is_push: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_INSERT) |-> (mode == MODE_PUSH && count != '0))
    else $error("scan without a push on a nonempty store");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP_RD) |-> (count == $past(count) - CNT_W'(1)))
    else $error("pop did not lower the count");
`endif

endmodule

`default_nettype wire

### hw/rtl/priority_stack_unit.sv
`default_nettype none

// bounded priority stack of up to 16 entries of (32-bit element, 8-bit priority).
// a push word puts its entry above every stored entry of lower or equal priority,
// so equal priorities leave last-in first-out; a pop word removes the top entry.
// every accepted word yields exactly one result word: top element and priority
// (zero when empty), empty flag, entry count and an error flag, which is set for
// a push on a full store or a pop on an empty one, and the store is then left as
// it was. entries live in a single-port-write, registered-read ram; a push walks
// down from the top with one compare per cycle, moving each higher-priority entry
// up one slot. a push onto an empty or full store skips the walk, and a pop that
// leaves the store empty or is refused skips the ram read. in_stall is high while
// an operation is in progress; a result may sit in the output register while the
// next operation runs, and the sequencer then holds its own result until that
// register frees up.
module priority_stack_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  psu_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output psu_pkg::out_word_t out_word
);
  import psu_pkg::*;

  seq_stat_t stat;
  out_word_t result;
  ram_req_t  ram_req;
  entry_t    ram_rdata;
  logic      start;
  logic      out_free;
  logic      out_load;

  // accept only while the sequencer sits idle
  assign in_stall = !stat.ready;
  assign start    = in_valid && stat.ready;

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  assign out_load = stat.done && out_free;

  psu_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .in_word  (in_word),
    .out_free (out_free),
    .stat     (stat),
    .result   (result),
    .ram_req  (ram_req),
    .rdata    (ram_rdata)
  );

  // entry store
  psu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_word <= result;
    end
  end

`ifndef ASSERT_OFF
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.is_empty == (out_word.entry_count == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule

`default_nettype wire
